// ===== hw/rtl/trs_pkg.sv =====
package trs_pkg;

  localparam int TABLE_ANGLES = 9;
  localparam int TABLE_SHIFTS = 6;
  localparam int CFG_AW       = 4;

  // Q2.14 cos(-a) and sin(-a), a = -60 .. 60 degrees in 15 degree steps
  localparam logic signed [15:0] ROT_COS [TABLE_ANGLES] = '{
    16'sd8192, 16'sd11585, 16'sd14189, 16'sd15826, 16'sd16384,
    16'sd15826, 16'sd14189, 16'sd11585, 16'sd8192
  };
  localparam logic signed [15:0] ROT_SIN [TABLE_ANGLES] = '{
    16'sd14189, 16'sd11585, 16'sd8192, 16'sd4240, 16'sd0,
    -16'sd4240, -16'sd8192, -16'sd11585, -16'sd14189
  };
  localparam logic [2:0] SHIFT_TAB [TABLE_SHIFTS] = '{
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6
  };

  localparam logic [1:0] REG_ROTATION = 2'd0;
  localparam logic [1:0] REG_SHIFT    = 2'd1;
  localparam logic [1:0] REG_INVERT   = 2'd2;

  typedef struct packed {
    logic              scroll;
    logic signed [7:0] rx;
    logic signed [7:0] ry;
    logic signed [8:0] add_h;
    logic signed [8:0] add_v;
    logic signed [7:0] wheel_h;
    logic signed [7:0] wheel_v;
  } trs_item_t;

endpackage

// ===== hw/rtl/trs_if.sv =====
interface trs_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] motion_x;
  logic signed [7:0] motion_y;
  logic signed [7:0] wheel_h_in;
  logic signed [7:0] wheel_v_in;
  logic              scroll_mode;

  modport source (output valid, motion_x, motion_y, wheel_h_in, wheel_v_in, scroll_mode,
                  input ready);
  modport sink (input valid, motion_x, motion_y, wheel_h_in, wheel_v_in, scroll_mode,
                output ready);
endinterface

interface trs_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] out_x;
  logic signed [7:0] out_y;
  logic signed [7:0] out_wheel_h;
  logic signed [7:0] out_wheel_v;

  modport source (output valid, out_x, out_y, out_wheel_h, out_wheel_v, input ready);
  modport sink (input valid, out_x, out_y, out_wheel_h, out_wheel_v, output ready);
endinterface

// ===== hw/rtl/trs_front.sv =====
module trs_front import trs_pkg::*; #(
  parameter int ANGLE_COUNT = 9
) (
  trs_in_if.sink     in_if,
  input  logic [3:0] rotation_index,
  input  logic       scroll_invert,
  input  logic       q_full,
  output logic       push,
  output trs_item_t  item
);

  localparam int AMAX = ((ANGLE_COUNT < TABLE_ANGLES) ? ANGLE_COUNT : TABLE_ANGLES) - 1;

  function automatic logic signed [7:0] rot_scale(input logic signed [24:0] sum);
    logic [24:0] mag;
    logic [10:0] q;
    logic signed [7:0] r;
    mag = sum[24] ? 25'(25'sd0 - sum) : 25'(sum);
    q   = mag[24:14];
    if (sum[24]) begin
      r = (q > 11'd128) ? -8'sd128 : 8'(11'd0 - q);
    end else begin
      r = (q > 11'd127) ? 8'sd127 : 8'(q);
    end
    return r;
  endfunction

  logic [3:0]         ai;
  logic signed [15:0] c;
  logic signed [15:0] s;
  logic signed [23:0] xc, ys, xs, yc;
  logic signed [7:0]  rx, ry;
  logic [7:0]         ax, ay;
  logic               h_win;
  logic signed [8:0]  rx9, ry9;

  assign ai = (rotation_index > 4'(AMAX)) ? 4'(AMAX) : rotation_index;
  assign c  = ROT_COS[ai];
  assign s  = ROT_SIN[ai];

  assign xc = 24'(in_if.motion_x) * 24'(c);
  assign ys = 24'(in_if.motion_y) * 24'(s);
  assign xs = 24'(in_if.motion_x) * 24'(s);
  assign yc = 24'(in_if.motion_y) * 24'(c);

  assign rx = rot_scale(25'(xc) - 25'(ys));
  assign ry = rot_scale(25'(xs) + 25'(yc));

  assign ax    = rx[7] ? 8'(8'd0 - rx) : rx;
  assign ay    = ry[7] ? 8'(8'd0 - ry) : ry;
  assign h_win = ax > ay;
  assign rx9   = 9'(rx);
  assign ry9   = 9'(ry);

  always_comb begin
    item.scroll  = in_if.scroll_mode;
    item.rx      = rx;
    item.ry      = ry;
    item.wheel_h = in_if.wheel_h_in;
    item.wheel_v = in_if.wheel_v_in;
    if (h_win) begin
      item.add_h = scroll_invert ? 9'(9'sd0 - rx9) : rx9;
      item.add_v = 9'sd0;
    end else begin
      item.add_h = 9'sd0;
      // vertical scroll runs opposite to motion
      item.add_v = scroll_invert ? ry9 : 9'(9'sd0 - ry9);
    end
  end

  assign in_if.ready = !q_full;
  assign push        = in_if.valid && !q_full;

endmodule

// ===== hw/rtl/trs_queue.sv =====
module trs_queue import trs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  trs_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output trs_item_t pop_item
);

  trs_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == 2'd2;
  assign valid    = cnt_r != 2'd0;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/trs_back.sv =====
module trs_back import trs_pkg::*; #(
  parameter int SHIFT_COUNT = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] shift_index,
  input  logic       item_valid,
  input  trs_item_t  item,
  output logic       pop,
  trs_out_if.source  out_if
);

  localparam int SMAX = ((SHIFT_COUNT < TABLE_SHIFTS) ? SHIFT_COUNT : TABLE_SHIFTS) - 1;

  typedef struct packed {
    logic signed [15:0] acc;
    logic signed [7:0]  wheel;
  } axis_res_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  function automatic axis_res_t apply_axis(input logic signed [15:0] acc,
                                           input logic signed [8:0]  add,
                                           input logic signed [7:0]  wheel,
                                           input logic [2:0]         sh);
    logic signed [15:0] a1;
    logic signed [15:0] q;
    logic signed [16:0] ws;
    logic signed [7:0]  nw;
    logic signed [9:0]  d;
    logic signed [18:0] dsh;
    axis_res_t          res;
    a1 = sat16(19'(acc) + 19'(add));
    q  = a1 >>> sh;
    ws = 17'(wheel) + 17'(q);
    if (ws > 17'sd127) begin
      nw = 8'sd127;
    end else if (ws < -17'sd127) begin
      nw = -8'sd127;
    end else begin
      nw = 8'(ws);
    end
    d   = 10'(nw) - 10'(wheel);
    dsh = 19'(d) <<< sh;
    if (q == 16'sd0) begin
      res.acc   = a1;
      res.wheel = wheel;
    end else begin
      res.acc   = sat16(19'(a1) - dsh);
      res.wheel = nw;
    end
    return res;
  endfunction

  logic [2:0]         si;
  logic [2:0]         sh;
  axis_res_t          h_res, v_res;
  logic signed [15:0] hacc_r, vacc_r;
  logic               out_valid_r;
  logic signed [7:0]  out_x_r, out_y_r, out_wh_r, out_wv_r;

  assign si    = (shift_index > 3'(SMAX)) ? 3'(SMAX) : shift_index;
  assign sh    = SHIFT_TAB[si];
  assign h_res = apply_axis(hacc_r, item.add_h, item.wheel_h, sh);
  assign v_res = apply_axis(vacc_r, item.add_v, item.wheel_v, sh);
  assign pop   = item_valid && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hacc_r      <= '0;
      vacc_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
      if (item.scroll) begin
        hacc_r <= h_res.acc;
        vacc_r <= v_res.acc;
      end
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (item.scroll) begin
        out_x_r  <= 8'sd0;
        out_y_r  <= 8'sd0;
        out_wh_r <= h_res.wheel;
        out_wv_r <= v_res.wheel;
      end else begin
        out_x_r  <= item.rx;
        out_y_r  <= item.ry;
        out_wh_r <= item.wheel_h;
        out_wv_r <= item.wheel_v;
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.out_x       = out_x_r;
  assign out_if.out_y       = out_y_r;
  assign out_if.out_wheel_h = out_wh_r;
  assign out_if.out_wheel_v = out_wv_r;

endmodule

// ===== hw/rtl/trackball_rotate_and_scroll.sv =====
// Rotates each motion report by a selectable angle and, in scroll mode, turns the
// dominant motion axis into wheel counts through two saturating 16-bit accumulators.
// The block takes one report per clock cycle while its output is taken, and passes
// each result through the queue and then the output register. The rate rests on the
// back end updating its accumulators as each report is taken. A two-entry queue
// sits between the rotation front end and the back end, and a registered output lets
// new reports come in while a result waits to be taken.
// Registers: rotation_index at 0x0, scroll_shift_index at 0x4, scroll_invert at 0x8.
module trackball_rotate_and_scroll import trs_pkg::*; #(
  parameter int ANGLE_COUNT = 9,
  parameter int SHIFT_COUNT = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  trs_in_if.sink            in_if,
  trs_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [3:0] rot_idx_r;
  logic [2:0] shift_idx_r;
  logic       invert_r;
  logic       cfg_wr;

  logic       push, q_full, q_valid, pop;
  trs_item_t  push_item, pop_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_idx_r   <= 4'd1;
      shift_idx_r <= 3'd4;
      invert_r    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROTATION: rot_idx_r   <= pwdata[3:0];
        REG_SHIFT:    shift_idx_r <= pwdata[2:0];
        REG_INVERT:   invert_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROTATION: prdata = {28'd0, rot_idx_r};
      REG_SHIFT:    prdata = {29'd0, shift_idx_r};
      REG_INVERT:   prdata = {31'd0, invert_r};
      default:      prdata = 32'd0;
    endcase
  end

  trs_front #(
    .ANGLE_COUNT(ANGLE_COUNT)
  ) u_front (
    .in_if          (in_if),
    .rotation_index (rot_idx_r),
    .scroll_invert  (invert_r),
    .q_full         (q_full),
    .push           (push),
    .item           (push_item)
  );

  trs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  trs_back #(
    .SHIFT_COUNT(SHIFT_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .shift_index (shift_idx_r),
    .item_valid  (q_valid),
    .item        (pop_item),
    .pop         (pop),
    .out_if      (out_if)
  );

endmodule
